[src/frml_pkg.sv]
package frml_pkg;

	localparam int TS_W       = 32;
	localparam int FPS_W      = 22;
	localparam int CFG_W      = 10;
	localparam int DLY_W      = 10;
	localparam int WINDOW_DEF = 10;

	// 1000 ms/s scaled by 2^8 for the Q8 rate
	localparam int RATE_NUM = 256000;
	localparam int RATE_W   = 18;
	localparam int MS_PER_S = 1000;

	localparam logic [CFG_W-1:0] MAX_FPS_RST = CFG_W'(60);
	localparam logic [FPS_W-1:0] FPS_IDLE_Q8 = FPS_W'(70 * 256);
	localparam logic [FPS_W-1:0] FPS_MAX_Q8  = {FPS_W{1'b1}};

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_UPD,
		ST_FPS,
		ST_FPS_W,
		ST_CAP,
		ST_CAP_W,
		ST_DONE
	} frml_state_t;

endpackage

[src/frml_div.sv]
module frml_div #(
	parameter int N_W = 22,
	parameter int D_W = 36
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	input  logic [N_W-1:0] dividend,
	input  logic [D_W-1:0] divisor,
	output logic           busy,
	output logic           done,
	output logic [N_W-1:0] quotient
);
	import frml_pkg::*;

	localparam int CW = $clog2(N_W + 1);

	logic [D_W-1:0] rem_q;
	logic [D_W-1:0] dsr_q;
	logic [N_W-1:0] quo_q;
	logic [CW-1:0]  cnt_q;
	logic           busy_q;
	logic           done_q;
	logic [D_W:0]   shifted;
	logic [D_W:0]   diff;
	logic           ge;

	// one quotient bit per cycle, restoring
	assign shifted = {rem_q, quo_q[N_W-1]};
	assign diff    = shifted - {1'b0, dsr_q};
	assign ge      = shifted >= {1'b0, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(N_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			dsr_q <= divisor;
			quo_q <= dividend;
		end else if (busy_q) begin
			rem_q <= ge ? diff[D_W-1:0] : shifted[D_W-1:0];
			quo_q <= {quo_q[N_W-2:0], ge};
		end
	end

	assign busy     = busy_q;
	assign done     = done_q;
	assign quotient = quo_q;

endmodule

[src/frml_win.sv]
module frml_win #(
	parameter int WINDOW = frml_pkg::WINDOW_DEF,
	localparam int CNT_W  = $clog2(WINDOW + 1),
	localparam int SUM_W  = frml_pkg::TS_W + CNT_W
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      rd_en,
	input  logic                      upd,
	input  logic [frml_pkg::TS_W-1:0] period,
	output logic [CNT_W-1:0]          count,
	output logic [SUM_W-1:0]          sum
);
	import frml_pkg::*;

	localparam int SLOT_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;

	logic [TS_W-1:0]   ring_mem [WINDOW];
	logic [TS_W-1:0]   old_q;
	logic [SLOT_W-1:0] slot_q;
	logic [CNT_W-1:0]  count_q;
	logic [SUM_W-1:0]  sum_q;
	logic              full;
	logic [SUM_W-1:0]  drop;

	assign full = count_q == CNT_W'(WINDOW);
	assign drop = full ? SUM_W'(old_q) : '0;

	always_ff @(posedge clk) begin
		if (rd_en) begin
			old_q <= ring_mem[slot_q];
		end
		if (upd) begin
			ring_mem[slot_q] <= period;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_q  <= '0;
			count_q <= '0;
			sum_q   <= '0;
		end else if (upd) begin
			sum_q  <= sum_q + SUM_W'(period) - drop;
			slot_q <= (slot_q == SLOT_W'(WINDOW - 1)) ? '0 : slot_q + 1'b1;
			if (!full) begin
				count_q <= count_q + 1'b1;
			end
		end
	end

	assign count = count_q;
	assign sum   = sum_q;

endmodule

[src/frame_rate_meter_limiter_core.sv]
// Frame rate meter and limiter.
// Input channel (in_valid/in_ready): one transfer per frame end, carrying the
// frame start and frame end millisecond timestamps. Each input gives exactly
// one output transfer (out_valid/out_ready): the frame period since the last
// frame end, the averaged rate over the last WINDOW periods in Q8, and the
// wait in ms needed to hold the configured rate cap.
// Config channel (cfg_valid/cfg_ready): writes max_fps; always ready, write
// only while no frame is in flight.
// Timing: one frame is handled at a time. A single restoring divider does
// the rate division and then the minimum period division, one quotient bit
// per cycle; N = max(clog2(WINDOW+1)+18, 22) bits each. The rate division
// is skipped when the window sum is zero; a new input can be taken in the
// cycle after the result is loaded into the output register.
// The output register holds its result while out_ready is low; the next
// frame may be accepted meanwhile but completes only after that transfer.
// Reset clears the history: the first frame reports period 0; max_fps = 60.
module frame_rate_meter_limiter_core #(
	parameter int WINDOW = frml_pkg::WINDOW_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_valid,
	output logic                       cfg_ready,
	input  logic [frml_pkg::CFG_W-1:0] max_fps,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic [frml_pkg::TS_W-1:0]  start_time,
	input  logic [frml_pkg::TS_W-1:0]  now_time,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic [frml_pkg::FPS_W-1:0] fps_q8,
	output logic [frml_pkg::TS_W-1:0]  frame_period,
	output logic [frml_pkg::DLY_W-1:0] delay_ms
);
	import frml_pkg::*;

	localparam int CNT_W = $clog2(WINDOW + 1);
	localparam int SUM_W = TS_W + CNT_W;
	localparam int NUM_W = CNT_W + RATE_W;
	localparam int DIV_N = (NUM_W > FPS_W) ? NUM_W : FPS_W;

	frml_state_t state_q, state_nx;

	logic [CFG_W-1:0] max_fps_q;
	logic [TS_W-1:0]  prev_end_q;
	logic             seen_q;
	logic [TS_W-1:0]  period_q;
	logic [TS_W-1:0]  elapsed_q;
	logic [FPS_W-1:0] fps_q;
	logic [DLY_W-1:0] delay_q;
	logic             out_valid_q;
	logic [FPS_W-1:0] out_fps_q;
	logic [TS_W-1:0]  out_period_q;
	logic [DLY_W-1:0] out_delay_q;

	logic             in_xfer;
	logic             out_free;
	logic             rd_en;
	logic             upd;
	logic             div_start;
	logic             div_busy;
	logic             div_done;
	logic [DIV_N-1:0] div_a;
	logic [SUM_W-1:0] div_b;
	logic [DIV_N-1:0] div_q;
	logic [CNT_W-1:0] count;
	logic [SUM_W-1:0] sum;
	logic             sum_zero;
	logic [CFG_W-1:0] cap;
	logic [TS_W-1:0]  min_period;

	assign cfg_ready = 1'b1;
	assign in_xfer   = in_valid && in_ready;
	assign out_free  = !out_valid_q || out_ready;
	assign sum_zero  = sum == '0;
	assign cap       = (max_fps_q == '0) ? CFG_W'(1) : max_fps_q;
	assign min_period = TS_W'(div_q[DLY_W-1:0]);

	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			ST_IDLE:  if (in_valid) state_nx = ST_UPD;
			ST_UPD:   state_nx = ST_FPS;
			ST_FPS:   state_nx = sum_zero ? ST_CAP : ST_FPS_W;
			ST_FPS_W: if (div_done) state_nx = ST_CAP;
			ST_CAP:   state_nx = ST_CAP_W;
			ST_CAP_W: if (div_done) state_nx = ST_DONE;
			ST_DONE:  if (out_free) state_nx = ST_IDLE;
			default:  state_nx = ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready  = state_q == ST_IDLE;
		rd_en     = in_ready && in_valid;
		upd       = state_q == ST_UPD;
		div_start = 1'b0;
		div_a     = DIV_N'(MS_PER_S);
		div_b     = SUM_W'(cap);
		unique case (state_q)
			ST_FPS: begin
				div_start = !sum_zero;
				div_a     = DIV_N'(NUM_W'(count) * NUM_W'(RATE_NUM));
				div_b     = sum;
			end
			ST_CAP:  div_start = 1'b1;
			default: div_start = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			max_fps_q   <= MAX_FPS_RST;
			prev_end_q  <= '0;
			seen_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (cfg_valid && cfg_ready) begin
				max_fps_q <= max_fps;
			end
			if (in_xfer) begin
				prev_end_q <= now_time;
				seen_q     <= 1'b1;
			end
			if (state_q == ST_DONE && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			period_q  <= seen_q ? now_time - prev_end_q : '0;
			elapsed_q <= now_time - start_time;
		end
		if (state_q == ST_FPS && sum_zero) begin
			fps_q <= FPS_IDLE_Q8;
		end else if (state_q == ST_FPS_W && div_done) begin
			fps_q <= (div_q > DIV_N'(FPS_MAX_Q8)) ? FPS_MAX_Q8 : div_q[FPS_W-1:0];
		end
		if (state_q == ST_CAP_W && div_done) begin
			delay_q <= (min_period > elapsed_q) ?
				DLY_W'(min_period - elapsed_q) : '0;
		end
		if (state_q == ST_DONE && out_free) begin
			out_fps_q    <= fps_q;
			out_period_q <= period_q;
			out_delay_q  <= delay_q;
		end
	end

	frml_win #(
		.WINDOW (WINDOW)
	) u_win (
		.clk    (clk),
		.arst_n (arst_n),
		.rd_en  (rd_en),
		.upd    (upd),
		.period (period_q),
		.count  (count),
		.sum    (sum)
	);

	frml_div #(
		.N_W (DIV_N),
		.D_W (SUM_W)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_a),
		.divisor  (div_b),
		.busy     (div_busy),
		.done     (div_done),
		.quotient (div_q)
	);

	assign out_valid    = out_valid_q;
	assign fps_q8       = out_fps_q;
	assign frame_period = out_period_q;
	assign delay_ms     = out_delay_q;

	a_div_idle_at_start: assert property (@(posedge clk) disable iff (!arst_n)
		div_start |-> !div_busy)
		else $error("divider started while busy");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count <= CNT_W'(WINDOW))
		else $error("window count above depth");

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		in_xfer |=> !in_ready)
		else $error("input taken while a frame is in flight");

	a_delay_bound: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> delay_ms <= DLY_W'(MS_PER_S))
		else $error("delay above one second");

endmodule

[tb/tb.sv]
`timescale 1ns / 100ps

module tb;
	import frml_pkg::*;

	localparam int HALF_PERIOD  = 6;
	localparam int RESET_CYCLES = 10;
	localparam int DRAIN_CYCLES = 64;
	localparam int CYCLE_LIMIT  = 1000000;
	localparam int PHASE_FRAMES = 250;
	localparam int PHASES       = 6;
	localparam int LONG_HOLD    = 400;

	typedef struct packed {
		logic [TS_W-1:0] start_ms;
		logic [TS_W-1:0] end_ms;
	} frame_t;

	typedef struct packed {
		logic [FPS_W-1:0] fps;
		logic [TS_W-1:0]  period;
		logic [DLY_W-1:0] delay;
	} meter_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_W-1:0] max_fps = '0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [TS_W-1:0] start_time = '0;
	logic [TS_W-1:0] now_time = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [FPS_W-1:0] fps_q8;
	logic [TS_W-1:0] frame_period;
	logic [DLY_W-1:0] delay_ms;

	frame_t pending_frames[$];
	meter_t meter_expected[$];

	// rate meter image
	logic [CFG_W-1:0] fps_cap = MAX_FPS_RST;
	logic [TS_W-1:0]  last_end = '0;
	logic             have_prev = 1'b0;
	logic [TS_W-1:0]  period_hist[WINDOW_DEF];
	int               hist_slot = 0;
	int               hist_count = 0;
	logic [63:0]      period_sum = '0;

	logic [TS_W-1:0] clock_ms = '0;
	logic steady = 1'b0;
	logic in_taken = 1'b0;
	int gap_left = 0;
	int stall_left = 0;
	int hold_left = 0;
	int hold_mark = -1;
	int results_seen = 0;
	int mismatches = 0;
	int cycle = 0;

	frame_rate_meter_limiter_core uut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.max_fps(max_fps),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.start_time(start_time),
		.now_time(now_time),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.fps_q8(fps_q8),
		.frame_period(frame_period),
		.delay_ms(delay_ms)
	);

	always #HALF_PERIOD clk = ~clk;

	task automatic log_mismatch(input string what);
		$display("mismatch at cycle %0d: %s", cycle, what);
		mismatches++;
	endtask

	function automatic meter_t rate_meter_step(input frame_t f);
		meter_t r;
		logic [63:0] q;
		logic [TS_W-1:0] min_period;
		logic [TS_W-1:0] elapsed;
		r.period = have_prev ? f.end_ms - last_end : '0;
		have_prev = 1'b1;
		last_end = f.end_ms;
		if (hist_count == WINDOW_DEF)
			period_sum -= period_hist[hist_slot];
		else
			hist_count++;
		period_hist[hist_slot] = r.period;
		period_sum += r.period;
		hist_slot = (hist_slot == WINDOW_DEF - 1) ? 0 : hist_slot + 1;
		if (period_sum == 0) begin
			r.fps = FPS_IDLE_Q8;
		end else begin
			q = (64'(hist_count) * 64'(RATE_NUM)) / period_sum;
			r.fps = (q > 64'(FPS_MAX_Q8)) ? FPS_MAX_Q8 : q[FPS_W-1:0];
		end
		// zero cap acts as 1 fps
		min_period = TS_W'(MS_PER_S) / ((fps_cap == '0) ? TS_W'(1) : TS_W'(fps_cap));
		elapsed = f.end_ms - f.start_ms;
		r.delay = (min_period > elapsed) ? DLY_W'(min_period - elapsed) : '0;
		return r;
	endfunction

	function automatic int idle_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		else if (r < 92)
			return $urandom_range(1, 4);
		return $urandom_range(10, 60);
	endfunction

	function automatic frame_t random_frame();
		frame_t f;
		int pick;
		logic [TS_W-1:0] elapsed;
		pick = $urandom_range(0, 99);
		if (pick < 12) begin
			f.start_ms = $urandom();
			f.end_ms = $urandom();
		end else begin
			if (pick < 14)
				clock_ms = $urandom();
			else if (pick < 16)
				clock_ms = 32'hFFFF_FFFF - $urandom_range(0, 300);
			pick = $urandom_range(0, 99);
			if (pick < 80)
				elapsed = $urandom_range(0, 40);
			else if (pick < 95)
				elapsed = $urandom_range(0, 1100);
			else
				elapsed = $urandom_range(0, 70000);
			f.start_ms = clock_ms + (($urandom_range(0, 4) == 0) ? 0 : $urandom_range(0, 4));
			f.end_ms = f.start_ms + elapsed;
		end
		clock_ms = f.end_ms;
		return f;
	endfunction

	task automatic write_fps_cap(input logic [CFG_W-1:0] value);
		@(negedge clk);
		cfg_valid <= 1'b1;
		max_fps <= value;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic wait_drained();
		while (pending_frames.size() != 0 || in_valid || meter_expected.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// frame driver
	always @(negedge clk) begin
		frame_t f;
		if (arst_n && !(in_valid && !in_taken)) begin
			if (gap_left > 0) begin
				gap_left--;
				in_valid <= 1'b0;
			end else if (pending_frames.size() != 0) begin
				f = pending_frames.pop_front();
				in_valid <= 1'b1;
				start_time <= f.start_ms;
				now_time <= f.end_ms;
				gap_left = steady ? 0 : idle_len();
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// result receiver
	always @(negedge clk) begin
		if (arst_n) begin
			if (results_seen != hold_mark && results_seen % 600 == 100) begin
				hold_mark = results_seen;
				hold_left = LONG_HOLD;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else if (stall_left > 0) begin
				stall_left--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
				if (!steady && $urandom_range(0, 3) == 0)
					stall_left = idle_len();
			end
		end
	end

	// transfer monitor and checker
	always @(posedge clk) begin
		meter_t want;
		if (arst_n) begin
			if (cfg_valid && cfg_ready)
				fps_cap = max_fps;
			in_taken = in_valid && in_ready;
			if (in_taken)
				meter_expected.push_back(rate_meter_step(frame_t'{start_time, now_time}));
			if (out_valid && out_ready) begin
				results_seen++;
				if (meter_expected.size() == 0) begin
					log_mismatch("result with nothing expected");
				end else begin
					want = meter_expected.pop_front();
					if (fps_q8 !== want.fps)
						log_mismatch($sformatf("fps_q8 got %0d want %0d", fps_q8, want.fps));
					if (frame_period !== want.period)
						log_mismatch($sformatf("frame_period got %0d want %0d",
							frame_period, want.period));
					if (delay_ms !== want.delay)
						log_mismatch($sformatf("delay_ms got %0d want %0d",
							delay_ms, want.delay));
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle++;
		if (cycle > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycle);
			$display("tb failed");
			$finish;
		end
	end

	initial begin
		logic [CFG_W-1:0] cap_plan[PHASES];
		int i;
		int p;
		cap_plan = '{10'd1, 10'd1000, 10'd0, 10'd1023, 10'd144, 10'd60};
		cap_plan[4] = $urandom_range(2, 999);
		repeat (RESET_CYCLES) @(negedge clk);
		arst_n <= 1'b1;

		// first frame, zero sums, wraps, long frames
		pending_frames.push_back(frame_t'{32'd0, 32'd0});
		pending_frames.push_back(frame_t'{32'd0, 32'd0});
		pending_frames.push_back(frame_t'{32'd5, 32'd10});
		pending_frames.push_back(frame_t'{32'd10, 32'd26});
		pending_frames.push_back(frame_t'{32'd30, 32'd29});
		pending_frames.push_back(frame_t'{32'hFFFF_FFFF, 32'hFFFF_FFFF});
		pending_frames.push_back(frame_t'{32'hFFFF_FFF0, 32'd5});
		pending_frames.push_back(frame_t'{32'd0, 32'hFFFF_FFFF});
		// one ms periods: fill the window and wrap the ring
		for (i = 0; i < 12; i++)
			pending_frames.push_back(frame_t'{32'(100 + i), 32'(100 + i)});
		pending_frames.push_back(frame_t'{32'd111, 32'd111});
		pending_frames.push_back(frame_t'{32'd200, 32'd1200});
		wait_drained();

		for (p = 0; p < PHASES; p++) begin
			write_fps_cap(cap_plan[p]);
			steady = (p == 2);
			for (i = 0; i < PHASE_FRAMES; i++)
				pending_frames.push_back(random_frame());
			wait_drained();
		end

		if (mismatches == 0)
			$display("tb passed");
		else
			$display("tb failed");
		$finish;
	end

endmodule
